[rtl/kmd_pkg.sv]
// kmd_pkg: shared types and constants of the key matrix debouncer
// no dependencies; used by kmd_ctrl, kmd_datapath and key_matrix_debounce

package kmd_pkg;

    localparam int ROWS  = 5;
    localparam int COLS  = 17;
    localparam int ROW_W = 3;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] RELOAD_RST = 8'd5;

    // configuration register indexes
    localparam logic REG_RELOAD = 1'b0;
    localparam logic REG_GHOST  = 1'b1;

    typedef logic [COLS-1:0]  t_cols;
    typedef logic [ROW_W-1:0] t_row;
    typedef logic [CNT_W-1:0] t_cnt;

    // controller to datapath
    typedef struct packed {
        logic take_in;
        logic load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

[rtl/kmd_ctrl.sv]
// kmd_ctrl: sequencing state machine of the key matrix debouncer
// depends on kmd_pkg; drives kmd_datapath through t_cmd

module kmd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  kmd_pkg::t_status i_status,
    output logic             o_in_ready,
    output kmd_pkg::t_cmd    o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EVAL = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_in_ready       = (r_state == S_IDLE);
        o_cmd.take_in    = i_in_valid && (r_state == S_IDLE);
        o_cmd.load_out   = (r_state == S_EVAL) && (!i_status.out_full || i_out_ready);
        n_state          = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.take_in) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/kmd_datapath.sv]
// kmd_datapath: raw and stable row stores, quiet counter, config and result register
// depends on kmd_pkg; controlled by kmd_ctrl

module kmd_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kmd_pkg::t_cmd     i_cmd,
    output kmd_pkg::t_status  o_status,
    input  logic              i_out_ready,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_wdata,
    input  kmd_pkg::t_row     i_row,
    input  kmd_pkg::t_cols    i_cols,
    input  logic              i_eos,
    output logic              o_out_valid,
    output kmd_pkg::t_row     o_echo_row,
    output kmd_pkg::t_cols    o_stable_bits,
    output logic              o_settled,
    output logic              o_bounce,
    output logic              o_commit,
    output logic              o_ghost
);

    kmd_pkg::t_cols r_raw    [kmd_pkg::ROWS];
    kmd_pkg::t_cols r_stable [kmd_pkg::ROWS];
    kmd_pkg::t_cols n_raw    [kmd_pkg::ROWS];
    kmd_pkg::t_cnt  r_cnt;
    kmd_pkg::t_cnt  n_cnt;
    kmd_pkg::t_cnt  r_reload;
    logic           r_ghost_en;

    // request held between accept and result
    kmd_pkg::t_row  r_row;
    logic           r_bounce;
    logic           r_commit;
    logic           n_bounce;
    logic           n_commit;

    logic           r_out_valid;
    kmd_pkg::t_row  r_echo_row;
    kmd_pkg::t_cols r_stable_bits;
    logic           r_settled;
    logic           r_bounce_o;
    logic           r_commit_o;
    logic           r_ghost_o;

    logic           changed;
    kmd_pkg::t_cnt  cnt_a;
    logic           row_ok;
    kmd_pkg::t_cols sel_bits;
    logic           overlap;
    logic           ghost;

    // update on accept: raw compare, reload, countdown, commit decision
    always_comb begin
        changed = 1'b0;
        for (int i = 0; i < kmd_pkg::ROWS; i++) begin
            n_raw[i] = r_raw[i];
            if (i_row == kmd_pkg::ROW_W'(i) && r_raw[i] != i_cols) begin
                changed  = 1'b1;
                n_raw[i] = i_cols;
            end
        end
        n_bounce = changed && (r_cnt != '0);
        if (changed) begin
            cnt_a = (r_reload != '0) ? r_reload : kmd_pkg::CNT_W'(1);
        end else begin
            cnt_a = r_cnt;
        end
        n_cnt    = cnt_a;
        n_commit = 1'b0;
        if (i_eos && cnt_a != '0) begin
            n_cnt    = cnt_a - kmd_pkg::CNT_W'(1);
            n_commit = (n_cnt == '0);
        end
    end

    // result from updated state
    always_comb begin
        row_ok   = 1'b0;
        sel_bits = '0;
        for (int i = 0; i < kmd_pkg::ROWS; i++) begin
            if (r_row == kmd_pkg::ROW_W'(i)) begin
                row_ok   = 1'b1;
                sel_bits = r_stable[i];
            end
        end
        overlap = 1'b0;
        for (int i = 0; i < kmd_pkg::ROWS; i++) begin
            if (r_row != kmd_pkg::ROW_W'(i) && (r_stable[i] & sel_bits) != '0) begin
                overlap = 1'b1;
            end
        end
        ghost = r_ghost_en && row_ok
                && ((sel_bits & (sel_bits - kmd_pkg::t_cols'(1))) != '0) && overlap;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < kmd_pkg::ROWS; i++) begin
                r_raw[i]    <= '0;
                r_stable[i] <= '0;
            end
            r_cnt       <= kmd_pkg::RELOAD_RST;
            r_reload    <= kmd_pkg::RELOAD_RST;
            r_ghost_en  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    kmd_pkg::REG_RELOAD: r_reload   <= i_cfg_wdata;
                    kmd_pkg::REG_GHOST:  r_ghost_en <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_cmd.take_in) begin
                r_cnt <= n_cnt;
                for (int i = 0; i < kmd_pkg::ROWS; i++) begin
                    r_raw[i] <= n_raw[i];
                    if (n_commit) begin
                        r_stable[i] <= n_raw[i];
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_row    <= i_row;
            r_bounce <= n_bounce;
            r_commit <= n_commit;
        end
        if (i_cmd.load_out) begin
            r_echo_row    <= r_row;
            r_stable_bits <= sel_bits;
            r_settled     <= (r_cnt == '0);
            r_bounce_o    <= r_bounce;
            r_commit_o    <= r_commit;
            r_ghost_o     <= ghost;
        end
    end

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_echo_row        = r_echo_row;
    assign o_stable_bits     = r_stable_bits;
    assign o_settled         = r_settled;
    assign o_bounce          = r_bounce_o;
    assign o_commit          = r_commit_o;
    assign o_ghost           = r_ghost_o;

endmodule

[rtl/key_matrix_debounce.sv]
// key_matrix_debounce: key matrix row debouncer with one global quiet counter
// depends on kmd_pkg, kmd_ctrl and kmd_datapath
//
// channel   direction  contents
// s_axis    in         tdata {column_bits, row_index}, tlast end_of_scan
// m_axis    out        tdata {stable_row_bits, echo_row},
//                      tuser {ghost_in_row, committed, bounce_seen, settled}
// cfg       in         index 0 debounce_reload, index 1 ghost_check_enable
//
// the accept cycle updates the row stores and counter; the evaluate state takes no new
// request and forms the result from the updated stable rows into the output register
// a new request is taken while the previous result waits in the output register
// a stalled output holds the result and the controller waits in its evaluate state
// synchronous reset clears all rows, sets the counter and reload to 5, ghost check off

module key_matrix_debounce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index[2:0], column_bits[19:3], zero fill
    input  logic        s_axis_tlast,   // end_of_scan
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // echo_row[2:0], stable_row_bits[19:3], zero fill
    output logic [3:0]  m_axis_tuser,   // settled, bounce_seen, committed, ghost_in_row
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    kmd_pkg::t_cmd    cmd;
    kmd_pkg::t_status status;
    kmd_pkg::t_row    echo_row;
    kmd_pkg::t_cols   stable_bits;
    logic             settled;
    logic             bounce;
    logic             commit;
    logic             ghost;

    kmd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (cmd)
    );

    kmd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_row         (s_axis_tdata[2:0]),
        .i_cols        (s_axis_tdata[19:3]),
        .i_eos         (s_axis_tlast),
        .o_out_valid   (m_axis_tvalid),
        .o_echo_row    (echo_row),
        .o_stable_bits (stable_bits),
        .o_settled     (settled),
        .o_bounce      (bounce),
        .o_commit      (commit),
        .o_ghost       (ghost)
    );

    assign m_axis_tdata = {4'b0000, stable_bits, echo_row};
    assign m_axis_tuser = {ghost, commit, bounce, settled};

endmodule

[tb/kmd_checker.sv]
`timescale 1ns / 100ps
// kmd_checker: watches the row sample, result and register channels of key_matrix_debounce,
// predicts each result from its own copy of the row stores and counter, and compares them
// depends on kmd_pkg

module kmd_checker
    import kmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index[2:0], column_bits[19:3], zero fill
    input  logic        s_axis_tlast,   // end_of_scan
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // echo_row[2:0], stable_row_bits[19:3], zero fill
    input  logic [3:0]  m_axis_tuser,   // settled, bounce_seen, committed, ghost_in_row
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_commits
);

    typedef struct packed {
        t_row  row;
        t_cols bits;
        logic  settled;
        logic  bounce;
        logic  commit;
        logic  ghost;
    } t_row_report;

    t_cols       raw_rows    [ROWS];
    t_cols       stable_rows [ROWS];
    t_cnt        quiet_cnt;
    t_cnt        reload_val;
    logic        ghost_en;
    t_row_report pending_reports [$];

    function automatic logic ghost_on_row(int r);
        t_cols bits;
        bits = stable_rows[r];
        if (((bits - t_cols'(1)) & bits) == '0)
            return 1'b0;
        for (int i = 0; i < ROWS; i++) begin
            if (i != r && (stable_rows[i] & bits) != '0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // compare and reload, then end of scan countdown and commit, then report
    function automatic t_row_report debounce_sample(t_row row, t_cols cols, logic eos);
        t_row_report rep;
        logic        in_range;
        rep      = '0;
        rep.row  = row;
        in_range = int'(row) < ROWS;
        if (in_range && raw_rows[row] != cols) begin
            raw_rows[row] = cols;
            rep.bounce    = quiet_cnt != '0;
            quiet_cnt     = (reload_val != '0) ? reload_val : t_cnt'(1);
        end
        if (eos && quiet_cnt != '0) begin
            quiet_cnt = quiet_cnt - t_cnt'(1);
            if (quiet_cnt == '0) begin
                stable_rows = raw_rows;
                rep.commit  = 1'b1;
            end
        end
        if (in_range) begin
            rep.bits  = stable_rows[row];
            rep.ghost = ghost_en && ghost_on_row(int'(row));
        end
        rep.settled = quiet_cnt == '0;
        return rep;
    endfunction

    always @(posedge i_clk) begin
        t_row_report got;
        t_row_report want;
        if (!i_rst_n) begin
            foreach (raw_rows[r]) begin
                raw_rows[r]    = '0;
                stable_rows[r] = '0;
            end
            quiet_cnt  = RELOAD_RST;
            reload_val = RELOAD_RST;
            ghost_en   = 1'b0;
            pending_reports.delete();
            o_errors  = 0;
            o_checked = 0;
            o_commits = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_RELOAD)
                    reload_val = i_cfg_wdata;
                else if (i_cfg_index == REG_GHOST)
                    ghost_en = i_cfg_wdata[0];
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_reports.push_back(debounce_sample(s_axis_tdata[2:0],
                                                          s_axis_tdata[19:3], s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                got.row     = m_axis_tdata[2:0];
                got.bits    = m_axis_tdata[19:3];
                got.settled = m_axis_tuser[0];
                got.bounce  = m_axis_tuser[1];
                got.commit  = m_axis_tuser[2];
                got.ghost   = m_axis_tuser[3];
                if (pending_reports.size() == 0) begin
                    $error("result for row %0d arrived with no request outstanding", got.row);
                    o_errors++;
                end else begin
                    want = pending_reports.pop_front();
                    o_checked++;
                    if (want.commit)
                        o_commits++;
                    if (got.row != want.row) begin
                        $error("echo_row: expected %0d, got %0d", want.row, got.row);
                        o_errors++;
                    end
                    if (got.bits != want.bits) begin
                        $error("stable_row_bits: expected 0x%05h, got 0x%05h",
                               want.bits, got.bits);
                        o_errors++;
                    end
                    if (got.settled != want.settled) begin
                        $error("settled: expected %0b, got %0b", want.settled, got.settled);
                        o_errors++;
                    end
                    if (got.bounce != want.bounce) begin
                        $error("bounce_seen: expected %0b, got %0b", want.bounce, got.bounce);
                        o_errors++;
                    end
                    if (got.commit != want.commit) begin
                        $error("committed: expected %0b, got %0b", want.commit, got.commit);
                        o_errors++;
                    end
                    if (got.ghost != want.ghost) begin
                        $error("ghost_in_row: expected %0b, got %0b", want.ghost, got.ghost);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = pending_reports.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// tb: drives row samples and register writes into key_matrix_debounce with random gaps
// and output stalls, and gives the verdict; depends on kmd_pkg and kmd_checker

module tb;
    import kmd_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [23:0] m_axis_tdata;
    logic [3:0]  m_axis_tuser;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_index   = REG_RELOAD;
    logic [7:0]  i_cfg_wdata   = '0;

    int    errors, pending, checked, commits;
    int    samples_sent  = 0;
    int    settings_used = 0;
    int    burst_left    = 0;
    logic  hold_off_req  = 1'b0;
    t_cols scan_pattern [ROWS];

    key_matrix_debounce u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    kmd_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_commits     (commits)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $error("run did not finish, %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // output side: stretches of steady, random and blocked ready, plus one long hold-off
    initial begin
        int stretch;
        int mode;
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (96) @(posedge i_clk);
            end else begin
                stretch = $urandom_range(4, 40);
                mode    = $urandom_range(0, 4);
                for (int c = 0; c < stretch; c++) begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        2:       m_axis_tready <= $urandom_range(0, 3) != 0;
                        3:       m_axis_tready <= c[0];
                        default: m_axis_tready <= c > stretch / 2;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_cols pick_pattern();
        t_cols p;
        int    n;
        p = '0;
        case ($urandom_range(0, 7))
            0: p = '0;
            1: p = t_cols'($urandom);
            default: begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    p[$urandom_range(0, 6)] = 1'b1;
            end
        endcase
        return p;
    endfunction

    task automatic offer_sample(input t_row row, input t_cols cols, input logic eos);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, cols, row};
        s_axis_tlast  <= eos;
        do @(posedge i_clk); while (!s_axis_tready);
        burst_left--;
        samples_sent++;
    endtask

    // registers change only once every outstanding request has been answered
    task automatic apply_setting(input t_cnt reload, input logic ghost);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_RELOAD;
        i_cfg_wdata <= reload;
        @(posedge i_clk);
        i_cfg_index <= REG_GHOST;
        i_cfg_wdata <= {7'($urandom), ghost};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // full scans with slowly changing rows, glitches, missing scan ends and stray samples
    task automatic run_scans(input int n_items);
        int    done;
        t_cols cols;
        done = 0;
        while (done < n_items) begin
            for (int r = 0; r < ROWS; r++) begin
                if ($urandom_range(0, 9) == 0)
                    scan_pattern[r] = pick_pattern();
                cols = scan_pattern[r];
                if ($urandom_range(0, 19) == 0)
                    cols[$urandom_range(0, COLS - 1)] ^= 1'b1;
                offer_sample(t_row'(r), cols, r == ROWS - 1 && $urandom_range(0, 15) != 0);
                done++;
                if ($urandom_range(0, 11) == 0) begin
                    offer_sample(t_row'($urandom_range(0, 7)), t_cols'($urandom),
                                 1'($urandom_range(0, 1)));
                    done++;
                end
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero reload acts as one scan, ghost flag on
        apply_setting(8'd0, 1'b1);
        offer_sample(3'd0, 17'h1FFFF, 1'b0);
        offer_sample(3'd1, 17'h00001, 1'b0);
        offer_sample(3'd4, 17'h10001, 1'b0);
        offer_sample(3'd7, 17'h1FFFF, 1'b1);
        offer_sample(3'd0, 17'h1FFFF, 1'b0);
        offer_sample(3'd4, 17'h10001, 1'b0);
        offer_sample(3'd1, 17'h00001, 1'b0);
        offer_sample(3'd2, 17'h00000, 1'b1);
        offer_sample(3'd5, 17'h0AAAA, 1'b0);
        offer_sample(3'd6, 17'h1FFFF, 1'b1);
        offer_sample(3'd3, 17'h15555, 1'b0);
        offer_sample(3'd3, 17'h0AAAA, 1'b1);
        offer_sample(3'd3, 17'h0AAAA, 1'b0);

        // longest reload, ghost flag off
        apply_setting(8'd255, 1'b0);
        offer_sample(3'd2, 17'h00003, 1'b1);
        offer_sample(3'd2, 17'h00003, 1'b1);
        offer_sample(3'd0, 17'h1FFFF, 1'b0);

        apply_setting(8'd1, 1'b0);
        offer_sample(3'd2, 17'h00000, 1'b0);
        offer_sample(3'd7, 17'h00000, 1'b1);
        offer_sample(3'd4, 17'h00000, 1'b1);

        foreach (scan_pattern[r])
            scan_pattern[r] = pick_pattern();
        apply_setting(8'd2, 1'b1);
        hold_off_req = 1'b1;
        run_scans(75);
        apply_setting(8'd5, 1'b0);
        run_scans(75);
        apply_setting(8'd1, 1'b1);
        run_scans(75);
        apply_setting(8'd3, 1'b1);
        run_scans(75);
        apply_setting(8'd0, 1'b0);
        run_scans(75);
        apply_setting(t_cnt'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
        run_scans(75);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("sent %0d row samples under %0d register settings", samples_sent, settings_used);
        $display("compared %0d results, %0d of them with a matrix commit", checked, commits);
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
